/* design/bms_pkg.sv */
// Shared constants, types and helpers for the bilinear map scaler.
// No dependencies; every other design file refers to it by scoped names.
package bms_pkg;

    // Map geometry: both sides are powers of two, split into four parity banks.
    localparam int MAP_COL_BITS    = 9;
    localparam int MAP_ROW_BITS    = 9;
    localparam int MAP_WIDTH       = 1 << MAP_COL_BITS;
    localparam int MAP_HEIGHT      = 1 << MAP_ROW_BITS;
    localparam int MAP_ADDR_BITS   = MAP_COL_BITS + MAP_ROW_BITS;
    localparam int MAX_OUTPUT_SIDE = 2048;

    localparam int BANK_COL_BITS  = MAP_COL_BITS - 1;
    localparam int BANK_ROW_BITS  = MAP_ROW_BITS - 1;
    localparam int BANK_ADDR_BITS = BANK_COL_BITS + BANK_ROW_BITS;
    localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;
    localparam int NUM_BANKS      = 4;
    localparam int BANK_SEL_BITS  = 2;

    // Field widths.
    localparam int PIX_BITS        = $clog2(MAX_OUTPUT_SIDE);
    localparam int TEXEL_ADDR_BITS = 18;
    localparam int COLOR_BITS      = 32;
    localparam int RGB_BITS        = 24;
    localparam int CHAN_BITS       = 8;
    localparam int NUM_CHANS       = 3;
    localparam int VIEW_BITS       = 9;
    localparam int STEP_BITS       = 24;

    // Fixed-point position and weights.
    localparam int FRAC_BITS    = 14;
    localparam int FRAC_MASK    = 16383;
    localparam int WEIGHT_SHIFT = 20;
    localparam int WEIGHT_FULL  = 255;
    localparam int WEIGHT_BITS  = 8;
    localparam int WPROD_BITS   = 2 * FRAC_BITS;
    localparam int CPROD_BITS   = CHAN_BITS + WEIGHT_BITS;
    localparam int CSUM_BITS    = CHAN_BITS + 2;
    localparam int PROD_BITS    = PIX_BITS + STEP_BITS;
    localparam int POS_BITS     = PROD_BITS + 1;
    localparam int INT_BITS     = POS_BITS - FRAC_BITS;

    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(16384);

    // Configuration port.
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic {
        MODE_LOAD   = 1'b0,
        MODE_RENDER = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        REG_VIEW_LEFT = 2'd0,
        REG_VIEW_TOP  = 2'd1,
        REG_STEP_X    = 2'd2,
        REG_STEP_Y    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [VIEW_BITS-1:0] view_left;
        logic [VIEW_BITS-1:0] view_top;
        logic [STEP_BITS-1:0] step_x;
        logic [STEP_BITS-1:0] step_y;
    } t_cfg;

    // Stage enables of the pipeline, driven by the top level.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic adv_o;
    } t_pipe_ctl;

    // One request after position calculation.
    typedef struct packed {
        t_mode                     mode;
        logic [MAP_COL_BITS-1:0]   col0;
        logic [MAP_COL_BITS-1:0]   col1;
        logic [MAP_ROW_BITS-1:0]   row0;
        logic [MAP_ROW_BITS-1:0]   row1;
        logic [FRAC_BITS-1:0]      fx;
        logic [FRAC_BITS-1:0]      fy;
        logic                      load_ok;
        logic [BANK_SEL_BITS-1:0]  load_bank;
        logic [BANK_ADDR_BITS-1:0] load_index;
        logic [COLOR_BITS-1:0]     color;
        logic [PIX_BITS-1:0]       px;
        logic [PIX_BITS-1:0]       py;
    } t_sample;

    // Bank number of a texel: row parity above column parity.
    function automatic logic [BANK_SEL_BITS-1:0] bank_of(
        input logic [MAP_ROW_BITS-1:0] row,
        input logic [MAP_COL_BITS-1:0] col
    );
        return {row[0], col[0]};
    endfunction

    // Entry of a texel within its bank.
    function automatic logic [BANK_ADDR_BITS-1:0] bank_index(
        input logic [MAP_ROW_BITS-1:0] row,
        input logic [MAP_COL_BITS-1:0] col
    );
        return {row[MAP_ROW_BITS-1:1], col[MAP_COL_BITS-1:1]};
    endfunction

endpackage

/* design/bms_req_if.sv */
// Request channel of the bilinear map scaler: valid, ready and one load or render request.
// Depends on bms_pkg for the field widths.
interface bms_req_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [bms_pkg::TEXEL_ADDR_BITS-1:0] texel_address;
    logic [bms_pkg::COLOR_BITS-1:0]      texel_color;
    logic [bms_pkg::PIX_BITS-1:0]        pixel_x;
    logic [bms_pkg::PIX_BITS-1:0]        pixel_y;

    modport source (
        output valid, mode, texel_address, texel_color, pixel_x, pixel_y,
        input  ready
    );
    modport sink (
        input  valid, mode, texel_address, texel_color, pixel_x, pixel_y,
        output ready
    );
endinterface

/* design/bms_res_if.sv */
// Result channel of the bilinear map scaler: valid, ready and one blended pixel.
// Depends on bms_pkg for the field widths.
interface bms_res_if;
    logic                         valid;
    logic                         ready;
    logic [bms_pkg::RGB_BITS-1:0] pixel_color;
    logic [bms_pkg::PIX_BITS-1:0] out_x;
    logic [bms_pkg::PIX_BITS-1:0] out_y;

    modport source (
        output valid, pixel_color, out_x, out_y,
        input  ready
    );
    modport sink (
        input  valid, pixel_color, out_x, out_y,
        output ready
    );
endinterface

/* design/bms_cfg_regs.sv */
// APB-style configuration registers of the bilinear map scaler.
// Depends on bms_pkg for the register map and the configuration struct.
module bms_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bms_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [bms_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [bms_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output bms_pkg::t_cfg                       o_cfg
);

    bms_pkg::t_cfg    r_cfg;
    bms_pkg::t_cfg    n_cfg;
    bms_pkg::t_reg_idx w_idx;
    logic             w_write;

    assign w_idx   = bms_pkg::t_reg_idx'(paddr[3:2]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (w_idx)
                bms_pkg::REG_VIEW_LEFT: n_cfg.view_left = pwdata[bms_pkg::VIEW_BITS-1:0];
                bms_pkg::REG_VIEW_TOP:  n_cfg.view_top  = pwdata[bms_pkg::VIEW_BITS-1:0];
                bms_pkg::REG_STEP_X:    n_cfg.step_x    = pwdata[bms_pkg::STEP_BITS-1:0];
                bms_pkg::REG_STEP_Y:    n_cfg.step_y    = pwdata[bms_pkg::STEP_BITS-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_left <= '0;
            r_cfg.view_top  <= '0;
            r_cfg.step_x    <= bms_pkg::STEP_RESET;
            r_cfg.step_y    <= bms_pkg::STEP_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            bms_pkg::REG_VIEW_LEFT: prdata = bms_pkg::APB_DATA_BITS'(r_cfg.view_left);
            bms_pkg::REG_VIEW_TOP:  prdata = bms_pkg::APB_DATA_BITS'(r_cfg.view_top);
            bms_pkg::REG_STEP_X:    prdata = bms_pkg::APB_DATA_BITS'(r_cfg.step_x);
            bms_pkg::REG_STEP_Y:    prdata = bms_pkg::APB_DATA_BITS'(r_cfg.step_y);
            default:                prdata = '0;
        endcase
    end

endmodule

/* design/bms_locate.sv */
// Position stages: multiplies the pixel position by the step, adds the view origin,
// clamps the four neighbours and splits load addresses into bank and entry. Uses bms_pkg.
module bms_locate (
    input  logic                                i_clk,
    input  bms_pkg::t_pipe_ctl                  i_ctl,
    input  bms_pkg::t_cfg                       i_cfg,
    input  logic                                i_mode,
    input  logic [bms_pkg::TEXEL_ADDR_BITS-1:0] i_texel_address,
    input  logic [bms_pkg::COLOR_BITS-1:0]      i_texel_color,
    input  logic [bms_pkg::PIX_BITS-1:0]        i_pixel_x,
    input  logic [bms_pkg::PIX_BITS-1:0]        i_pixel_y,
    output bms_pkg::t_sample                    o_sample
);

    // Stage one: products.
    bms_pkg::t_mode                      r_mode;
    logic [bms_pkg::PROD_BITS-1:0]       r_prod_x;
    logic [bms_pkg::PROD_BITS-1:0]       r_prod_y;
    logic [bms_pkg::PIX_BITS-1:0]        r_px;
    logic [bms_pkg::PIX_BITS-1:0]        r_py;
    logic [bms_pkg::TEXEL_ADDR_BITS-1:0] r_addr;
    logic [bms_pkg::COLOR_BITS-1:0]      r_color;

    // Stage two: neighbour positions.
    bms_pkg::t_sample                    r_sample;
    bms_pkg::t_sample                    n_sample;

    logic [bms_pkg::POS_BITS-1:0]        w_pos_x;
    logic [bms_pkg::POS_BITS-1:0]        w_pos_y;
    logic [bms_pkg::INT_BITS-1:0]        w_int_x;
    logic [bms_pkg::INT_BITS-1:0]        w_int_y;
    logic [bms_pkg::MAP_ROW_BITS-1:0]    w_load_row;
    logic [bms_pkg::MAP_COL_BITS-1:0]    w_load_col;

    localparam logic [bms_pkg::INT_BITS-1:0] LAST_COL =
        bms_pkg::INT_BITS'(bms_pkg::MAP_WIDTH - 1);
    localparam logic [bms_pkg::INT_BITS-1:0] LAST_ROW =
        bms_pkg::INT_BITS'(bms_pkg::MAP_HEIGHT - 1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_mode   <= bms_pkg::t_mode'(i_mode);
            r_prod_x <= bms_pkg::PROD_BITS'(i_pixel_x) * bms_pkg::PROD_BITS'(i_cfg.step_x);
            r_prod_y <= bms_pkg::PROD_BITS'(i_pixel_y) * bms_pkg::PROD_BITS'(i_cfg.step_y);
            r_px     <= i_pixel_x;
            r_py     <= i_pixel_y;
            r_addr   <= i_texel_address;
            r_color  <= i_texel_color;
        end
    end

    assign w_pos_x = (bms_pkg::POS_BITS'(i_cfg.view_left) << bms_pkg::FRAC_BITS)
                   + bms_pkg::POS_BITS'(r_prod_x);
    assign w_pos_y = (bms_pkg::POS_BITS'(i_cfg.view_top) << bms_pkg::FRAC_BITS)
                   + bms_pkg::POS_BITS'(r_prod_y);
    assign w_int_x = w_pos_x[bms_pkg::POS_BITS-1:bms_pkg::FRAC_BITS];
    assign w_int_y = w_pos_y[bms_pkg::POS_BITS-1:bms_pkg::FRAC_BITS];

    assign w_load_col = r_addr[bms_pkg::MAP_COL_BITS-1:0];
    assign w_load_row = r_addr[bms_pkg::MAP_COL_BITS +: bms_pkg::MAP_ROW_BITS];

    always_comb begin
        n_sample.mode = r_mode;

        // Neighbours past the last column or row saturate; fractions stay as they are.
        n_sample.col0 = (w_int_x > LAST_COL) ? LAST_COL[bms_pkg::MAP_COL_BITS-1:0]
                                             : w_int_x[bms_pkg::MAP_COL_BITS-1:0];
        n_sample.col1 = (w_int_x >= LAST_COL) ? LAST_COL[bms_pkg::MAP_COL_BITS-1:0]
                      : w_int_x[bms_pkg::MAP_COL_BITS-1:0] + bms_pkg::MAP_COL_BITS'(1);
        n_sample.row0 = (w_int_y > LAST_ROW) ? LAST_ROW[bms_pkg::MAP_ROW_BITS-1:0]
                                             : w_int_y[bms_pkg::MAP_ROW_BITS-1:0];
        n_sample.row1 = (w_int_y >= LAST_ROW) ? LAST_ROW[bms_pkg::MAP_ROW_BITS-1:0]
                      : w_int_y[bms_pkg::MAP_ROW_BITS-1:0] + bms_pkg::MAP_ROW_BITS'(1);
        n_sample.fx   = w_pos_x[bms_pkg::FRAC_BITS-1:0];
        n_sample.fy   = w_pos_y[bms_pkg::FRAC_BITS-1:0];

        // A load address beyond the map is dropped.
        n_sample.load_ok    = ((r_addr >> bms_pkg::MAP_ADDR_BITS) == '0);
        n_sample.load_bank  = bms_pkg::bank_of(w_load_row, w_load_col);
        n_sample.load_index = bms_pkg::bank_index(w_load_row, w_load_col);
        n_sample.color      = r_color;
        n_sample.px         = r_px;
        n_sample.py         = r_py;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

/* design/bms_map_store.sv */
// Colour map in four single-port parity banks, each with a registered read port.
// Depends on bms_pkg for the bank geometry and the sample struct.
module bms_map_store (
    input  logic                                                  i_clk,
    input  bms_pkg::t_pipe_ctl                                    i_ctl,
    input  logic                                                  i_valid,
    input  bms_pkg::t_sample                                      i_sample,
    output logic [bms_pkg::NUM_BANKS-1:0][bms_pkg::COLOR_BITS-1:0] o_texel
);

    logic w_write;
    logic w_read;

    // Loads and renders meet the banks at the same stage, so in-order access needs no forwarding.
    assign w_write = i_ctl.en3 && i_valid && (i_sample.mode == bms_pkg::MODE_LOAD)
                   && i_sample.load_ok;
    assign w_read  = i_ctl.en3 && i_valid && (i_sample.mode == bms_pkg::MODE_RENDER);

    for (genvar b = 0; b < bms_pkg::NUM_BANKS; b++) begin : g_bank
        localparam logic [bms_pkg::BANK_SEL_BITS-1:0] BANK = bms_pkg::BANK_SEL_BITS'(b);

        logic [bms_pkg::COLOR_BITS-1:0]     r_mem [bms_pkg::BANK_DEPTH];
        logic [bms_pkg::COLOR_BITS-1:0]     r_q;
        logic [bms_pkg::MAP_ROW_BITS-1:0]   w_row;
        logic [bms_pkg::MAP_COL_BITS-1:0]   w_col;
        logic [bms_pkg::BANK_ADDR_BITS-1:0] w_addr;
        logic                               w_we;

        // The neighbour rows differ in parity unless clamped to one row, likewise columns.
        assign w_row  = (i_sample.row0[0] == BANK[1]) ? i_sample.row0 : i_sample.row1;
        assign w_col  = (i_sample.col0[0] == BANK[0]) ? i_sample.col0 : i_sample.col1;
        assign w_we   = w_write && (i_sample.load_bank == BANK);
        assign w_addr = w_we ? i_sample.load_index : bms_pkg::bank_index(w_row, w_col);

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[w_addr] <= i_sample.color;
            end
            if (w_read) begin
                r_q <= r_mem[w_addr];
            end
        end

        assign o_texel[b] = r_q;
    end

endmodule

/* design/bms_blend.sv */
// Weight calculation and bilinear blend of the four neighbour texels into one RGB pixel.
// Depends on bms_pkg for widths and the sample struct.
module bms_blend (
    input  logic                                                  i_clk,
    input  bms_pkg::t_pipe_ctl                                    i_ctl,
    input  bms_pkg::t_sample                                      i_sample,
    input  logic [bms_pkg::NUM_BANKS-1:0][bms_pkg::COLOR_BITS-1:0] i_texel,
    output logic [bms_pkg::RGB_BITS-1:0]                          o_pixel_color,
    output logic [bms_pkg::PIX_BITS-1:0]                          o_out_x,
    output logic [bms_pkg::PIX_BITS-1:0]                          o_out_y
);

    localparam logic [bms_pkg::FRAC_BITS-1:0] FMASK =
        bms_pkg::FRAC_BITS'(bms_pkg::FRAC_MASK);
    localparam logic [bms_pkg::WEIGHT_BITS-1:0] WFULL =
        bms_pkg::WEIGHT_BITS'(bms_pkg::WEIGHT_FULL);

    logic [bms_pkg::FRAC_BITS-1:0]   w_nfx;
    logic [bms_pkg::FRAC_BITS-1:0]   w_nfy;
    logic [bms_pkg::WPROD_BITS-1:0]  w_p0;
    logic [bms_pkg::WPROD_BITS-1:0]  w_p1;
    logic [bms_pkg::WPROD_BITS-1:0]  w_p2;
    logic [bms_pkg::NUM_BANKS-1:0][bms_pkg::WEIGHT_BITS-1:0]   n_w;
    logic [bms_pkg::NUM_BANKS-1:0][bms_pkg::WEIGHT_BITS-1:0]   r_w;
    logic [bms_pkg::NUM_BANKS-1:0][bms_pkg::BANK_SEL_BITS-1:0] n_sel;
    logic [bms_pkg::NUM_BANKS-1:0][bms_pkg::BANK_SEL_BITS-1:0] r_sel;
    logic [bms_pkg::PIX_BITS-1:0]    r_px;
    logic [bms_pkg::PIX_BITS-1:0]    r_py;

    logic [bms_pkg::RGB_BITS-1:0]    n_pixel_color;
    logic [bms_pkg::RGB_BITS-1:0]    r_pixel_color;
    logic [bms_pkg::PIX_BITS-1:0]    r_out_x;
    logic [bms_pkg::PIX_BITS-1:0]    r_out_y;
    logic [bms_pkg::CPROD_BITS-1:0]  w_cprod;
    logic [bms_pkg::CSUM_BITS-1:0]   w_csum;

    assign w_nfx = FMASK - i_sample.fx;
    assign w_nfy = FMASK - i_sample.fy;
    assign w_p0  = bms_pkg::WPROD_BITS'(w_nfx) * bms_pkg::WPROD_BITS'(w_nfy);
    assign w_p1  = bms_pkg::WPROD_BITS'(i_sample.fx) * bms_pkg::WPROD_BITS'(w_nfy);
    assign w_p2  = bms_pkg::WPROD_BITS'(w_nfx) * bms_pkg::WPROD_BITS'(i_sample.fy);

    always_comb begin
        n_w[0] = w_p0[bms_pkg::WEIGHT_SHIFT +: bms_pkg::WEIGHT_BITS];
        n_w[1] = w_p1[bms_pkg::WEIGHT_SHIFT +: bms_pkg::WEIGHT_BITS];
        n_w[2] = w_p2[bms_pkg::WEIGHT_SHIFT +: bms_pkg::WEIGHT_BITS];
        // The last weight takes up the remainder, modulo 256.
        n_w[3] = WFULL - n_w[0] - n_w[1] - n_w[2];

        n_sel[0] = bms_pkg::bank_of(i_sample.row0, i_sample.col0);
        n_sel[1] = bms_pkg::bank_of(i_sample.row0, i_sample.col1);
        n_sel[2] = bms_pkg::bank_of(i_sample.row1, i_sample.col0);
        n_sel[3] = bms_pkg::bank_of(i_sample.row1, i_sample.col1);
    end

    // Weights travel alongside the bank reads issued in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_w   <= n_w;
            r_sel <= n_sel;
            r_px  <= i_sample.px;
            r_py  <= i_sample.py;
        end
    end

    always_comb begin
        n_pixel_color = '0;
        w_cprod       = '0;
        w_csum        = '0;
        for (int c = 0; c < bms_pkg::NUM_CHANS; c++) begin
            w_csum = '0;
            for (int k = 0; k < bms_pkg::NUM_BANKS; k++) begin
                w_cprod = bms_pkg::CPROD_BITS'(i_texel[r_sel[k]][c*bms_pkg::CHAN_BITS +:
                                                                   bms_pkg::CHAN_BITS])
                        * bms_pkg::CPROD_BITS'(r_w[k]);
                w_csum  = w_csum + bms_pkg::CSUM_BITS'(
                              w_cprod[bms_pkg::CPROD_BITS-1:bms_pkg::WEIGHT_BITS]);
            end
            n_pixel_color[c*bms_pkg::CHAN_BITS +: bms_pkg::CHAN_BITS] =
                w_csum[bms_pkg::CHAN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_o) begin
            r_pixel_color <= n_pixel_color;
            r_out_x       <= r_px;
            r_out_y       <= r_py;
        end
    end

    assign o_pixel_color = r_pixel_color;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;

endmodule

/* design/bilinear_map_scaler.sv */
// A render request passes stage one, stage two, stage three and the output register in turn
// before it is offered at the output; loads give no result.
// Throughput: one request per cycle; ready falls only when stages one to three and the output
// register are all full and the output is stalled. The map banks are single ported and take
// one load or one render per cycle. Reset clears the stage valid bits and the configuration registers;
// the map is not cleared, its contents are undefined until loaded, and no pass runs.
module bilinear_map_scaler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bms_req_if.sink                           i_req,
    bms_res_if.source                         o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bms_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [bms_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [bms_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);

    // The pipeline has four registered stages:
    //   stage one    multiplies the pixel position by the step,
    //   stage two    adds the view origin, clamps the neighbours and splits load addresses,
    //   stage three  holds the bank read data and the four weights,
    //   output       holds the blended colour until the sink takes it.
    // Each stage advances when the stage after it is empty or advancing itself, so
    // bubbles close up and a waiting result does not stop new requests entering.

    bms_pkg::t_cfg      w_cfg;
    bms_pkg::t_pipe_ctl w_ctl;
    bms_pkg::t_sample   w_sample;
    logic [bms_pkg::NUM_BANKS-1:0][bms_pkg::COLOR_BITS-1:0] w_texel;

    logic r_v1, r_v2, r_v3, r_vo;
    logic n_v1, n_v2, n_v3, n_vo;

    always_comb begin
        w_ctl.adv_o = !r_vo || o_res.ready;
        w_ctl.en3   = !r_v3 || w_ctl.adv_o;
        w_ctl.en2   = !r_v2 || w_ctl.en3;
        w_ctl.en1   = !r_v1 || w_ctl.en2;
    end

    assign i_req.ready = w_ctl.en1;

    // A load finishes when it writes the bank, so only renders go on past stage two.
    always_comb begin
        n_v1 = w_ctl.en1   ? i_req.valid : r_v1;
        n_v2 = w_ctl.en2   ? r_v1        : r_v2;
        n_v3 = w_ctl.en3   ? (r_v2 && (w_sample.mode == bms_pkg::MODE_RENDER)) : r_v3;
        n_vo = w_ctl.adv_o ? r_v3        : r_vo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            r_vo <= n_vo;
        end
    end

    assign o_res.valid = r_vo;

    bms_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bms_locate u_locate (
        .i_clk           (i_clk),
        .i_ctl           (w_ctl),
        .i_cfg           (w_cfg),
        .i_mode          (i_req.mode),
        .i_texel_address (i_req.texel_address),
        .i_texel_color   (i_req.texel_color),
        .i_pixel_x       (i_req.pixel_x),
        .i_pixel_y       (i_req.pixel_y),
        .o_sample        (w_sample)
    );

    // Loads write and renders read the banks in stage order, so a render always sees
    // every load that was accepted before it.
    bms_map_store u_map_store (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_valid  (r_v2),
        .i_sample (w_sample),
        .o_texel  (w_texel)
    );

    bms_blend u_blend (
        .i_clk         (i_clk),
        .i_ctl         (w_ctl),
        .i_sample      (w_sample),
        .i_texel       (w_texel),
        .o_pixel_color (o_res.pixel_color),
        .o_out_x       (o_res.out_x),
        .o_out_y       (o_res.out_y)
    );

endmodule

/* design/bms_checker.sv */
// Port-level assertions for the bilinear map scaler, and the bind that attaches them.
// Depends on bms_pkg for widths and the mode codes.
module bms_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_req_mode,
    input logic [bms_pkg::PIX_BITS-1:0] i_req_pixel_x,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic [bms_pkg::PIX_BITS-1:0] i_res_out_x
);

    logic w_fire;
    assign w_fire = i_req_valid && i_req_ready;

    // A result that is not taken stays offered.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result withdrawn before it was taken");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result offered straight after reset");

    // With the sink always ready, a render comes out with its column once it has passed the pipeline.
    a_render_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (i_req_mode == bms_pkg::MODE_RENDER) && i_res_ready
         ##1 i_res_ready ##1 i_res_ready ##1 i_res_ready)
        |=> (i_res_valid && (i_res_out_x == $past(i_req_pixel_x, 4))))
        else $error("render result missing or wrong column after four cycles");

    // A load never produces a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (i_req_mode == bms_pkg::MODE_LOAD) && i_res_ready
         ##1 i_res_ready ##1 i_res_ready ##1 i_res_ready)
        |=> !i_res_valid)
        else $error("load produced a result");

endmodule

bind bilinear_map_scaler bms_checker u_bms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_mode    (i_req.mode),
    .i_req_pixel_x (i_req.pixel_x),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_out_x   (o_res.out_x)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the bilinear map scaler: loads texels, renders pixels and
// compares every blended pixel against a predictor kept inside the testbench.
// Depends on bms_pkg, the bms_req_if and bms_res_if interfaces and bilinear_map_scaler.
module tb_top;
    import bms_pkg::*;

    localparam int MAP_CELLS    = MAP_WIDTH * MAP_HEIGHT;
    // Three pipeline stages plus the output register, with a good margin on top.
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1200;

    // One blended pixel as it should leave the block.
    typedef struct packed {
        logic [RGB_BITS-1:0] color;
        logic [PIX_BITS-1:0] x;
        logic [PIX_BITS-1:0] y;
    } t_pixel_result;

    // The four neighbour texels of a sample position and its fractions.
    typedef struct packed {
        logic [3:0][MAP_ADDR_BITS-1:0] addr;
        logic [FRAC_BITS-1:0]          fx;
        logic [FRAC_BITS-1:0]          fy;
    } t_footprint;

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_SLOW
    } t_sink_pattern;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    bms_req_if req_if ();
    bms_res_if res_if ();

    bilinear_map_scaler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the configuration registers, updated once a write has landed.
    logic [VIEW_BITS-1:0] cfg_view_left;
    logic [VIEW_BITS-1:0] cfg_view_top;
    logic [STEP_BITS-1:0] cfg_step_x;
    logic [STEP_BITS-1:0] cfg_step_y;

    // Shadow copy of the colour map. The loaded flags keep every render away from
    // entries that have never been written, whose contents the block leaves undefined.
    logic [COLOR_BITS-1:0] texel_map    [MAP_CELLS];
    bit                    texel_loaded [MAP_CELLS];

    // Pixels predicted for accepted render requests, oldest first.
    t_pixel_result pending_pixels [$];
    t_pixel_result want_pixel;

    int error_count;
    int requests_sent;
    // Set by a test to ask the result sink for a long hold-off; the sink counts it down.
    int hold_request;

    always #10 i_clk = ~i_clk;

    // Works out where an output pixel falls in the map. The position is kept at full
    // width, so large steps never wrap; the integer parts then saturate at the last
    // column and row, whereas the fractions are kept as they are.
    function automatic t_footprint locate_sample(input logic [PIX_BITS-1:0] px,
                                                 input logic [PIX_BITS-1:0] py);
        logic [39:0]             xp;
        logic [39:0]             yp;
        logic [25:0]             col_int;
        logic [25:0]             row_int;
        logic [MAP_COL_BITS-1:0] c0;
        logic [MAP_COL_BITS-1:0] c1;
        logic [MAP_ROW_BITS-1:0] r0;
        logic [MAP_ROW_BITS-1:0] r1;
        t_footprint              fp;
        xp = (40'(cfg_view_left) << FRAC_BITS) + 40'(px) * 40'(cfg_step_x);
        yp = (40'(cfg_view_top) << FRAC_BITS) + 40'(py) * 40'(cfg_step_y);
        fp.fx   = xp[FRAC_BITS-1:0];
        fp.fy   = yp[FRAC_BITS-1:0];
        col_int = xp[39:FRAC_BITS];
        row_int = yp[39:FRAC_BITS];
        c0 = (col_int > MAP_WIDTH - 1)      ? MAP_COL_BITS'(MAP_WIDTH - 1)
                                            : col_int[MAP_COL_BITS-1:0];
        c1 = (col_int + 1 > MAP_WIDTH - 1)  ? MAP_COL_BITS'(MAP_WIDTH - 1)
                                            : MAP_COL_BITS'(col_int + 1);
        r0 = (row_int > MAP_HEIGHT - 1)     ? MAP_ROW_BITS'(MAP_HEIGHT - 1)
                                            : row_int[MAP_ROW_BITS-1:0];
        r1 = (row_int + 1 > MAP_HEIGHT - 1) ? MAP_ROW_BITS'(MAP_HEIGHT - 1)
                                            : MAP_ROW_BITS'(row_int + 1);
        fp.addr[0] = {r0, c0};
        fp.addr[1] = {r0, c1};
        fp.addr[2] = {r1, c0};
        fp.addr[3] = {r1, c1};
        return fp;
    endfunction

    // Bilinear blend of the four neighbours. The fourth weight takes up whatever the
    // other three leave of 255, and each channel is truncated after every product.
    function automatic logic [RGB_BITS-1:0] blend_pixel(input logic [PIX_BITS-1:0] px,
                                                        input logic [PIX_BITS-1:0] py);
        t_footprint            fp;
        logic [FRAC_BITS-1:0]  gx;
        logic [FRAC_BITS-1:0]  gy;
        logic [3:0][7:0]       w;
        logic [COLOR_BITS-1:0] texel;
        logic [9:0]            chan_sum;
        logic [RGB_BITS-1:0]   rgb;
        fp   = locate_sample(px, py);
        gx   = FRAC_BITS'(FRAC_MASK) - fp.fx;
        gy   = FRAC_BITS'(FRAC_MASK) - fp.fy;
        w[0] = 8'((32'(gx) * 32'(gy)) >> WEIGHT_SHIFT);
        w[1] = 8'((32'(fp.fx) * 32'(gy)) >> WEIGHT_SHIFT);
        w[2] = 8'((32'(gx) * 32'(fp.fy)) >> WEIGHT_SHIFT);
        w[3] = 8'(WEIGHT_FULL - (32'(w[0]) + 32'(w[1]) + 32'(w[2])));
        rgb  = '0;
        for (int ch = 0; ch < NUM_CHANS; ch++) begin
            chan_sum = '0;
            for (int k = 0; k < 4; k++) begin
                texel    = texel_map[fp.addr[k]];
                chan_sum = chan_sum + 10'((16'(texel[8*ch +: 8]) * 16'(w[k])) >> 8);
            end
            rgb[8*ch +: 8] = chan_sum[7:0];
        end
        return rgb;
    endfunction

    // Offers one request and holds it until the block takes it. Ready is sampled on the
    // falling edge, so the request is known to be accepted at the following rising edge;
    // the shadow state is updated at that point, in request order. Valid is left high so
    // that a following request can go out on the very next cycle.
    task automatic send_req(input t_mode                      mode,
                            input logic [TEXEL_ADDR_BITS-1:0] addr,
                            input logic [COLOR_BITS-1:0]      color,
                            input logic [PIX_BITS-1:0]        px,
                            input logic [PIX_BITS-1:0]        py);
        bit            taken;
        t_pixel_result expected_pixel;
        taken = 1'b0;
        req_if.valid         <= 1'b1;
        req_if.mode          <= mode;
        req_if.texel_address <= addr;
        req_if.texel_color   <= color;
        req_if.pixel_x       <= px;
        req_if.pixel_y       <= py;
        while (!taken) begin
            @(negedge i_clk);
            if (req_if.ready === 1'b1) begin
                taken = 1'b1;
                requests_sent++;
                if (mode == MODE_LOAD) begin
                    // Every 18-bit address lies inside a 512 by 512 map.
                    texel_map[addr]    = color;
                    texel_loaded[addr] = 1'b1;
                end else begin
                    expected_pixel.color = blend_pixel(px, py);
                    expected_pixel.x     = px;
                    expected_pixel.y     = py;
                    pending_pixels.push_back(expected_pixel);
                end
            end
            @(posedge i_clk);
        end
    endtask

    // Loads any neighbour texel that is still undefined, then renders the pixel. The
    // loads go out back to back just ahead of the render, which also exercises the
    // case of a render reading a texel written just before it.
    task automatic render_pixel(input logic [PIX_BITS-1:0] px,
                                input logic [PIX_BITS-1:0] py);
        t_footprint fp;
        fp = locate_sample(px, py);
        for (int k = 0; k < 4; k++) begin
            if (!texel_loaded[fp.addr[k]]) begin
                send_req(MODE_LOAD, fp.addr[k], $urandom,
                         PIX_BITS'($urandom), PIX_BITS'($urandom));
            end
        end
        send_req(MODE_RENDER, TEXEL_ADDR_BITS'($urandom), $urandom, px, py);
    endtask

    // When no gap is asked for, valid must be left alone: the next request raises it
    // again in this same time step.
    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            req_if.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stops offering requests and waits until every predicted pixel has arrived. Loads
    // leave no trace at the output, so a further wait lets the pipeline empty.
    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write with a setup and an access phase, only ever done on an idle block.
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_BITS-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (pready !== 1'b1) @(negedge i_clk);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_VIEW_LEFT: cfg_view_left = value[VIEW_BITS-1:0];
            REG_VIEW_TOP:  cfg_view_top  = value[VIEW_BITS-1:0];
            REG_STEP_X:    cfg_step_x    = value[STEP_BITS-1:0];
            REG_STEP_Y:    cfg_step_y    = value[STEP_BITS-1:0];
            default:       ;
        endcase
    endtask

    function automatic logic [APB_DATA_BITS-1:0] pick_view();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return MAP_WIDTH - 1;
            default: return $urandom_range(0, MAP_WIDTH - 1);
        endcase
    endfunction

    // Modest steps for a third of the picks, so that footprints overlap and texels get reused,
    // with zero, the reset step, 8388608 and random steps up to it mixed in.
    function automatic logic [APB_DATA_BITS-1:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 8388608;
            2:       return STEP_RESET;
            3:       return $urandom_range(0, 8388608);
            default: return $urandom_range(1, 40000);
        endcase
    endfunction

    // Extremes of the texel and pixel fields, every register, fractional weights,
    // clamping at the far edge, zero steps and the overwrite of a texel in use.
    task automatic test_corner_cases();
        // Full-scale and empty texels around the origin, sampled with zero fractions.
        send_req(MODE_LOAD, 18'd0, 32'hFFFF_FFFF, '1, '1);
        send_req(MODE_LOAD, 18'd1, 32'h0000_0000, '0, '0);
        send_req(MODE_LOAD, 18'(MAP_WIDTH), 32'hFF00_FF00, '1, '0);
        send_req(MODE_LOAD, 18'(MAP_WIDTH + 1), 32'h00FF_00FF, '0, '1);
        render_pixel(0, 0);
        // Far corner: the whole footprint saturates onto the last texel.
        send_req(MODE_LOAD, 18'(MAP_CELLS - 1), 32'hFFFF_FFFF, '1, '1);
        render_pixel(11'h7FF, 11'h7FF);
        // Half and quarter steps give non-zero fractions and all four weights.
        write_reg(REG_STEP_X, 32'h0000_2000);
        write_reg(REG_STEP_Y, 32'h0000_1000);
        render_pixel(1, 1);
        render_pixel(3, 3);
        // Overwrite a texel that is already in use and read it straight back.
        send_req(MODE_LOAD, 18'd1, 32'h8080_8080, '0, '0);
        render_pixel(1, 1);
        // View at the last column and row, step 8388608 in x and zero in y: every neighbour clamps.
        write_reg(REG_VIEW_LEFT, MAP_WIDTH - 1);
        write_reg(REG_VIEW_TOP, MAP_HEIGHT - 1);
        write_reg(REG_STEP_X, 32'd8388608);
        write_reg(REG_STEP_Y, 32'd0);
        render_pixel(0, 0);
        render_pixel(11'h7FF, 1);
        // Zero steps: any pixel lands on the view origin.
        write_reg(REG_VIEW_LEFT, 5);
        write_reg(REG_VIEW_TOP, 9);
        write_reg(REG_STEP_X, 32'd0);
        render_pixel(11'd1234, 11'd567);
        write_reg(REG_STEP_X, 32'(STEP_RESET));
        write_reg(REG_STEP_Y, 32'(STEP_RESET));
        render_pixel(2, 3);
    endtask

    // The sink holds off for a long stretch while renders keep coming, so the pipeline
    // and its output register fill and the block has to drop its ready. Afterwards the
    // sender pauses until every pixel is out.
    task automatic test_backpressure();
        drain_results();
        hold_request = 80;
        for (int n = 0; n < 24; n++) begin
            render_pixel(PIX_BITS'($urandom_range(0, 7)), PIX_BITS'($urandom_range(0, 7)));
        end
        drain_results();
    endtask

    // Phases of random traffic, each under its own register setting. Most requests are
    // renders preceded by the loads they need; the rest are loads to random addresses.
    task automatic test_random_traffic();
        int start_count;
        int phase_end;
        int span;
        int burst;
        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_ITEMS) begin
            write_reg(REG_VIEW_LEFT, pick_view());
            write_reg(REG_VIEW_TOP, pick_view());
            write_reg(REG_STEP_X, pick_step());
            write_reg(REG_STEP_Y, pick_step());
            span      = ($urandom_range(0, 3) == 0) ? MAX_OUTPUT_SIDE - 1
                                                    : $urandom_range(1, 40);
            phase_end = requests_sent + $urandom_range(120, 250);
            while (requests_sent < phase_end) begin
                burst = $urandom_range(1, 20);
                for (int n = 0; n < burst; n++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_req(MODE_LOAD, TEXEL_ADDR_BITS'($urandom), $urandom,
                                 PIX_BITS'($urandom), PIX_BITS'($urandom));
                    end else begin
                        render_pixel(PIX_BITS'($urandom_range(0, span)),
                                     PIX_BITS'($urandom_range(0, span)));
                    end
                end
                // A quarter of the bursts run straight into the next one.
                if ($urandom_range(0, 3) != 0) begin
                    idle_sender($urandom_range(1, 8));
                end
            end
        end
    endtask

    // Result sink: ready follows a pattern that changes every so often, and a requested
    // hold-off overrides it for the number of cycles asked.
    initial begin : result_sink
        int            hold_left;
        int            pattern_left;
        t_sink_pattern pattern;
        hold_left    = 0;
        pattern_left = 0;
        pattern      = SINK_ALWAYS;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (pattern_left == 0) begin
                pattern      = t_sink_pattern'($urandom_range(0, 2));
                pattern_left = $urandom_range(16, 160);
            end else begin
                pattern_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                case (pattern)
                    SINK_ALWAYS: res_if.ready <= 1'b1;
                    SINK_RANDOM: res_if.ready <= 1'($urandom_range(0, 1));
                    default:     res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Pixel checker: a pixel is taken at the rising edge after a falling edge that sees
    // valid and ready both high, and is compared with the oldest prediction.
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel x=%0d y=%0d color=%06h", $time,
                         res_if.out_x, res_if.out_y, res_if.pixel_color);
                error_count++;
            end else begin
                want_pixel = pending_pixels.pop_front();
                if (res_if.pixel_color !== want_pixel.color) begin
                    $display("%0t: pixel_color mismatch: expected %06h, actual %06h",
                             $time, want_pixel.color, res_if.pixel_color);
                    error_count++;
                end
                if (res_if.out_x !== want_pixel.x) begin
                    $display("%0t: out_x mismatch: expected %0d, actual %0d",
                             $time, want_pixel.x, res_if.out_x);
                    error_count++;
                end
                if (res_if.out_y !== want_pixel.y) begin
                    $display("%0t: out_y mismatch: expected %0d, actual %0d",
                             $time, want_pixel.y, res_if.out_y);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("bilinear_map_scaler test failed");
        $finish;
    end

    initial begin
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        req_if.valid         <= 1'b0;
        req_if.mode          <= MODE_LOAD;
        req_if.texel_address <= '0;
        req_if.texel_color   <= '0;
        req_if.pixel_x       <= '0;
        req_if.pixel_y       <= '0;
        error_count   = 0;
        requests_sent = 0;
        hold_request  = 0;
        cfg_view_left = '0;
        cfg_view_top  = '0;
        cfg_step_x    = STEP_RESET;
        cfg_step_y    = STEP_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_cases();
        test_backpressure();
        test_random_traffic();

        drain_results();
        if (error_count == 0) begin
            $display("bilinear_map_scaler test passed");
        end else begin
            $display("bilinear_map_scaler test failed");
        end
        $finish;
    end

endmodule
